// ----- rtl/core/ffpa_pkg.sv -----
// Package for the first-fit partition allocator.
// Holds the opcode and status codes, the sequencer state type and the default sizes.
// No dependencies.
package ffpa_pkg;

  // Default sizes for the top-level parameters
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int LENGTH_BITS_DEF = 16;

  // Request opcodes
  localparam logic [1:0] OP_APPEND  = 2'd0;
  localparam logic [1:0] OP_ALLOC   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_NO_OWNER = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_WALK_DN,
    S_WALK_UP,
    S_WR_MERGE,
    S_SHIFT,
    S_WR_REST,
    S_WR_HEAD,
    S_DONE
  } state_t;

endpackage

// ----- rtl/core/first_fit_partition_allocator_unit.sv -----
// First-fit partition allocator: partition table in a single-port-write memory,
// walked by one shared compare/add unit under a small sequencer.
// Depends on ffpa_pkg.
//
//  channel  | direction | tdata fields (lowest bit first)
//  s_axis   | in        | opcode[1:0], process_id[9:2], request_length[25:10]
//  m_axis   | out       | status[1:0], entry_index[5:2], entry_count[10:6]
//
// Steps per item: append and unknown opcodes go from accept straight to the
// result. Allocate scans the entries; a split then moves the entries after
// the split point up by one and writes the free rest and the used head.
// Release scans the entries, walks the free neighbours below and above,
// writes the merged entry and moves the entries after the merged run down.
// The one memory read port paces every scan and move, one entry per cycle.
// Reset clears the entry count and the control state; the table memory is
// not cleared, entries at or above the count are never read.
// One item is worked on at a time; a finished result waits in the output
// register, and the next result waits in the sequencer until it is taken.
module first_fit_partition_allocator_unit
  import ffpa_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // opcode, process_id, request_length
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // status, entry_index, entry_count
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = LENGTH_BITS + 9;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // Partition table: {used, owner, length}
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] mem_rdata;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;
  logic [EW-1:0] mem_wdata;

  // Sequencer registers
  state_t           state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [1:0]       op, op_next;
  logic [7:0]       pid, pid_next;
  logic [LENGTH_BITS-1:0] len, len_next;
  logic [CW-1:0]    ptr, ptr_next;
  logic             chk, chk_next;
  logic [IW-1:0]    chk_idx, chk_idx_next;
  logic [IW-1:0]    f, f_next;
  logic [LENGTH_BITS-1:0] ent_len, ent_len_next;
  logic [IW-1:0]    lo, lo_next;
  logic [IW-1:0]    hi, hi_next;
  logic [LENGTH_BITS-1:0] sum, sum_next;
  logic [IW-1:0]    rm, rm_next;
  logic [CW-1:0]    sp, sp_next;
  logic [CW-1:0]    mv_left, mv_left_next;
  logic             pend, pend_next;
  logic [IW-1:0]    pend_dst, pend_dst_next;
  logic [1:0]       res_status, res_status_next;
  logic [IW-1:0]    res_idx, res_idx_next;
  logic             out_load;

  // Input item fields
  logic [1:0]             in_op;
  logic [7:0]             in_pid;
  logic [LENGTH_BITS-1:0] in_len;

  // Read data fields
  logic [LENGTH_BITS-1:0] rd_len;
  logic [7:0]             rd_own;
  logic                   rd_used;

  // Shared compare / add unit
  logic                   hit;
  logic [LENGTH_BITS:0]   add_wide;
  logic [LENGTH_BITS-1:0] add_sat;

  logic [31:0] idx_ext;
  logic [31:0] cnt_ext;

  assign in_op   = s_axis_tdata[1:0];
  assign in_pid  = s_axis_tdata[9:2];
  assign in_len  = LENGTH_BITS'(s_axis_tdata[25:10]);

  assign rd_len  = mem_rdata[LENGTH_BITS-1:0];
  assign rd_own  = mem_rdata[LENGTH_BITS+7:LENGTH_BITS];
  assign rd_used = mem_rdata[LENGTH_BITS+8];

  // Scan predicate: free and long enough, or used by the requesting owner
  assign hit = chk && ((op == OP_ALLOC) ? (!rd_used && (rd_len >= len))
                                        : (rd_used && (rd_own == pid)));

  // Saturating accumulate of merged lengths
  assign add_wide = {1'b0, sum} + {1'b0, rd_len};
  assign add_sat  = add_wide[LENGTH_BITS] ? LEN_MAX : add_wide[LENGTH_BITS-1:0];

  assign s_axis_tready = (state == S_IDLE);
  assign out_load      = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  assign idx_ext = 32'(res_idx);
  assign cnt_ext = 32'(count);

  // Table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Next state and datapath control
  always_comb begin
    state_next      = state;
    count_next      = count;
    op_next         = op;
    pid_next        = pid;
    len_next        = len;
    ptr_next        = ptr;
    chk_next        = chk;
    chk_idx_next    = chk_idx;
    f_next          = f;
    ent_len_next    = ent_len;
    lo_next         = lo;
    hi_next         = hi;
    sum_next        = sum;
    rm_next         = rm;
    sp_next         = sp;
    mv_left_next    = mv_left;
    pend_next       = pend;
    pend_dst_next   = pend_dst;
    res_status_next = res_status;
    res_idx_next    = res_idx;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_raddr       = '0;

    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_next  = in_op;
          pid_next = in_pid;
          len_next = in_len;
          ptr_next = '0;
          chk_next = 1'b0;
          case (in_op)
            OP_APPEND: begin
              if (count >= DEPTH_C) begin
                res_status_next = ST_FULL;
                res_idx_next    = '0;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = count[IW-1:0];
                mem_wdata       = {1'b0, 8'd0, in_len};
                count_next      = count + ONE_C;
                res_status_next = ST_OK;
                res_idx_next    = count[IW-1:0];
              end
              state_next = S_DONE;
            end
            OP_ALLOC, OP_RELEASE: begin
              state_next = S_SCAN;
            end
            default: begin
              res_status_next = ST_OK;
              res_idx_next    = '0;
              state_next      = S_DONE;
            end
          endcase
        end
      end

      // First-fit or owner search, one entry per cycle
      S_SCAN: begin
        if (hit) begin
          f_next       = chk_idx;
          ent_len_next = rd_len;
          chk_next     = 1'b0;
          if (op == OP_ALLOC) begin
            if (rd_len == len) begin
              mem_we          = 1'b1;
              mem_waddr       = chk_idx;
              mem_wdata       = {1'b1, pid, len};
              res_status_next = ST_OK;
              res_idx_next    = chk_idx;
              state_next      = S_DONE;
            end else if (count >= DEPTH_C) begin
              res_status_next = ST_FULL;
              res_idx_next    = '0;
              state_next      = S_DONE;
            end else begin
              sp_next      = count - ONE_C;
              mv_left_next = count - ONE_C - CW'(chk_idx);
              pend_next    = 1'b0;
              state_next   = S_SHIFT;
            end
          end else begin
            sum_next   = rd_len;
            lo_next    = chk_idx;
            hi_next    = chk_idx;
            ptr_next   = CW'(chk_idx);
            state_next = S_WALK_DN;
          end
        end else if (ptr < count) begin
          mem_raddr    = ptr[IW-1:0];
          chk_next     = 1'b1;
          chk_idx_next = ptr[IW-1:0];
          ptr_next     = ptr + ONE_C;
        end else begin
          res_status_next = (op == OP_ALLOC) ? ST_NO_FIT : ST_NO_OWNER;
          res_idx_next    = '0;
          chk_next        = 1'b0;
          state_next      = S_DONE;
        end
      end

      // Free run below the released entry
      S_WALK_DN: begin
        if (chk && rd_used) begin
          chk_next   = 1'b0;
          ptr_next   = CW'(f);
          state_next = S_WALK_UP;
        end else begin
          if (chk) begin
            sum_next = add_sat;
            lo_next  = chk_idx;
          end
          if (ptr == '0) begin
            chk_next   = 1'b0;
            ptr_next   = CW'(f);
            state_next = S_WALK_UP;
          end else begin
            mem_raddr    = IW'(ptr - ONE_C);
            chk_next     = 1'b1;
            chk_idx_next = IW'(ptr - ONE_C);
            ptr_next     = ptr - ONE_C;
          end
        end
      end

      // Free run above the released entry
      S_WALK_UP: begin
        if (chk && rd_used) begin
          chk_next   = 1'b0;
          state_next = S_WR_MERGE;
        end else begin
          if (chk) begin
            sum_next = add_sat;
            hi_next  = chk_idx;
          end
          if ((ptr + ONE_C) >= count) begin
            chk_next   = 1'b0;
            state_next = S_WR_MERGE;
          end else begin
            mem_raddr    = IW'(ptr + ONE_C);
            chk_next     = 1'b1;
            chk_idx_next = IW'(ptr + ONE_C);
            ptr_next     = ptr + ONE_C;
          end
        end
      end

      // Merged free entry, then close the gap
      S_WR_MERGE: begin
        mem_we       = 1'b1;
        mem_waddr    = lo;
        mem_wdata    = {1'b0, 8'd0, sum};
        rm_next      = hi - lo;
        sp_next      = CW'(hi) + ONE_C;
        mv_left_next = count - ONE_C - CW'(hi);
        pend_next    = 1'b0;
        state_next   = S_SHIFT;
      end

      // Entry move: up by one for a split, down by rm after a merge
      S_SHIFT: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_dst;
          mem_wdata = mem_rdata;
        end
        if (mv_left != '0) begin
          mem_raddr    = sp[IW-1:0];
          pend_next    = 1'b1;
          mv_left_next = mv_left - ONE_C;
          if (op == OP_ALLOC) begin
            pend_dst_next = IW'(sp + ONE_C);
            sp_next       = sp - ONE_C;
          end else begin
            pend_dst_next = IW'(sp - CW'(rm));
            sp_next       = sp + ONE_C;
          end
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            if (op == OP_ALLOC) begin
              state_next = S_WR_REST;
            end else begin
              count_next      = count - CW'(rm);
              res_status_next = ST_OK;
              res_idx_next    = lo;
              state_next      = S_DONE;
            end
          end
        end
      end

      // Free remainder after the split point
      S_WR_REST: begin
        mem_we     = 1'b1;
        mem_waddr  = IW'(f + IW'(1));
        mem_wdata  = {1'b0, 8'd0, ent_len - len};
        state_next = S_WR_HEAD;
      end

      // Used head of the split entry
      S_WR_HEAD: begin
        mem_we          = 1'b1;
        mem_waddr       = f;
        mem_wdata       = {1'b1, pid, len};
        count_next      = count + ONE_C;
        res_status_next = ST_OK;
        res_idx_next    = f;
        state_next      = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      chk           <= 1'b0;
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      chk   <= chk_next;
      pend  <= pend_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op         <= op_next;
    pid        <= pid_next;
    len        <= len_next;
    ptr        <= ptr_next;
    chk_idx    <= chk_idx_next;
    f          <= f_next;
    ent_len    <= ent_len_next;
    lo         <= lo_next;
    hi         <= hi_next;
    sum        <= sum_next;
    rm         <= rm_next;
    sp         <= sp_next;
    mv_left    <= mv_left_next;
    pend_dst   <= pend_dst_next;
    res_status <= res_status_next;
    res_idx    <= res_idx_next;
    if (out_load) begin
      m_axis_tdata <= {5'd0, cnt_ext[4:0], idx_ext[3:0], res_status};
    end
  end

`ifndef SYNTHESIS
  // Entry count stays within the table
  assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("entry count beyond table depth");

  // Neighbour walks only read the table
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_DN || state == S_WALK_UP) |-> !mem_we)
    else $error("table write during merge walk");

  // One item at a time: an accepted item closes the input
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input reopened straight after accept");

  // A new result only comes from the completion state
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_DONE)
    else $error("result raised outside completion");

  // Failed requests report index zero
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1:0] != ST_OK) |-> m_axis_tdata[5:2] == 4'd0)
    else $error("non-zero index on failed request");
`endif

endmodule
